// ===== sv/logic_sample_runlength_expander_defines.svh =====
// ----------------------------------------------------------------------------
// logic_sample_runlength_expander_defines.svh
// Assertion macros shared by the expander checker.
// ----------------------------------------------------------------------------
`ifndef LOGIC_SAMPLE_RUNLENGTH_EXPANDER_DEFINES_SVH
`define LOGIC_SAMPLE_RUNLENGTH_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, silent while arst_n is low.
`define LSRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, silent while arst_n is low.
`define LSRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lsre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsre_pkg
// Types and constants of the logic sample run-length expander.
// ----------------------------------------------------------------------------
package lsre_pkg;

	localparam int RAW_W    = 64;
	localparam int SAMPLE_W = 58;
	localparam int RLC_W    = 3;
	localparam int DW_W     = 6;
	localparam int TRIG_W   = 16;
	localparam int CNT_W    = 6;   // run count minus one, widest case
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_RLC_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_IDX  = 2'd2;

	// Reset values of the registers
	localparam logic [RLC_W-1:0]  RST_RLC_WIDTH  = 3'd0;
	localparam logic [DW_W-1:0]   RST_SAMPLE_BITS = 6'd8;
	localparam logic [TRIG_W-1:0] RST_TRIGGER    = 16'd0;

	typedef struct packed {
		logic [RAW_W-1:0] raw_word;
		logic             last_raw;
	} raw_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                pre_trigger;
		logic                run_last;
		logic                capture_last;
	} sample_item_t;

	typedef struct packed {
		logic [RLC_W-1:0]  rlc_width;
		logic [DW_W-1:0]   sample_bits;
		logic [TRIG_W-1:0] trigger_raw_index;
	} cfg_t;

	// One classified raw word, waiting for expansion
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                pre_trigger;
		logic                capture;
		logic [CNT_W-1:0]    cnt_m1;
	} run_entry_t;

endpackage

// ===== sv/lsre_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsre_front
// Split each raw word into run count and sample, tag it against the trigger.
// ----------------------------------------------------------------------------
module lsre_front #(
	parameter int MAX_RLC_WIDTH   = 6,
	parameter int RAW_INDEX_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsre_pkg::cfg_t      cfg,
	input  logic                raw_valid,
	output logic                raw_ready,
	input  lsre_pkg::raw_item_t raw_item,
	output logic                push_valid,
	input  logic                push_ready,
	output lsre_pkg::run_entry_t push_entry
);
	import lsre_pkg::*;

	localparam int CMP_W = (RAW_INDEX_WIDTH > TRIG_W) ? RAW_INDEX_WIDTH : TRIG_W;
	localparam logic [RAW_INDEX_WIDTH-1:0] IDX_MAX = {RAW_INDEX_WIDTH{1'b1}};

	logic [RAW_INDEX_WIDTH-1:0] raw_index_q;
	logic [RLC_W-1:0]           rw;
	logic [DW_W-1:0]            dw;
	logic [RAW_W-1:0]           shifted;
	logic [SAMPLE_W-1:0]        dmask;
	logic [CNT_W-1:0]           cmask;
	logic                       accept;

	assign raw_ready  = push_ready;
	assign push_valid = raw_valid;
	assign accept     = raw_valid && push_ready;

	always_comb begin
		// clamp the field widths to what the hardware supports
		rw = (cfg.rlc_width > RLC_W'(MAX_RLC_WIDTH)) ? RLC_W'(MAX_RLC_WIDTH) : cfg.rlc_width;
		dw = (cfg.sample_bits > DW_W'(SAMPLE_W)) ? DW_W'(SAMPLE_W) : cfg.sample_bits;
		shifted = raw_item.raw_word >> rw;
		dmask   = ~({SAMPLE_W{1'b1}} << dw);
		cmask   = ~({CNT_W{1'b1}} << rw);
		push_entry.sample      = shifted[SAMPLE_W-1:0] & dmask;
		push_entry.cnt_m1      = raw_item.raw_word[CNT_W-1:0] & cmask;
		push_entry.pre_trigger = CMP_W'(raw_index_q) < CMP_W'(cfg.trigger_raw_index);
		push_entry.capture     = raw_item.last_raw;
	end

	// advance the word index, saturate, restart after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_index_q <= '0;
		end else if (accept) begin
			if (raw_item.last_raw) begin
				raw_index_q <= '0;
			end else if (raw_index_q != IDX_MAX) begin
				raw_index_q <= raw_index_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/lsre_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsre_queue
// Short first-in first-out queue of classified runs.
// ----------------------------------------------------------------------------
module lsre_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  lsre_pkg::run_entry_t push_entry,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output lsre_pkg::run_entry_t pop_entry
);
	import lsre_pkg::*;

	run_entry_t        entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lsre_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsre_back
// Emit one copy of the current run per cycle into the output register, unless smp_ready stalls it.
// ----------------------------------------------------------------------------
module lsre_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  lsre_pkg::run_entry_t   pop_entry,
	output logic                   smp_valid,
	input  logic                   smp_ready,
	output lsre_pkg::sample_item_t smp_item
);
	import lsre_pkg::*;

	logic             out_valid_q;
	sample_item_t     out_item_q;
	logic [CNT_W-1:0] rem_q;       // copies still owed after the one on show
	logic             cur_cap_q;
	logic             out_free;
	logic             more;
	logic             take;

	assign out_free  = !out_valid_q || smp_ready;
	assign more      = (rem_q != '0);
	assign pop_ready = out_free && !more;
	assign take      = pop_ready && pop_valid;
	assign smp_valid = out_valid_q;
	assign smp_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (out_free) begin
			if (more) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_q - 1'b1;
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				rem_q       <= pop_entry.cnt_m1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && more) begin
			out_item_q.run_last     <= (rem_q == CNT_W'(1));
			out_item_q.capture_last <= (rem_q == CNT_W'(1)) && cur_cap_q;
		end else if (take) begin
			out_item_q.sample       <= pop_entry.sample;
			out_item_q.pre_trigger  <= pop_entry.pre_trigger;
			out_item_q.run_last     <= (pop_entry.cnt_m1 == '0);
			out_item_q.capture_last <= (pop_entry.cnt_m1 == '0) && pop_entry.capture;
			cur_cap_q               <= pop_entry.capture;
		end
	end

endmodule

// ===== sv/logic_sample_runlength_expander.sv =====
`timescale 1ns / 1ps
// A raw item passes through the run queue, then the output register, before its first sample shows.
// One sample item per cycle while smp_ready is high; a raw item yields count+1 copies
// (1 to 64), set by the single output register that emits one copy per cycle.
// Raw items keep flowing while the four-entry run queue has room.
// Reset (arst_n low, asynchronous): queue and output emptied, word index zeroed,
// registers back to rlc_width 0, eight sample bits, trigger_raw_index 0.
// ----------------------------------------------------------------------------
// logic_sample_runlength_expander
// Expand run-length coded capture words into tagged logic samples.
// ----------------------------------------------------------------------------
module logic_sample_runlength_expander #(
	parameter int MAX_RLC_WIDTH   = 6,
	parameter int RAW_INDEX_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [lsre_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [lsre_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// raw capture words
	input  logic                               raw_valid,
	output logic                               raw_ready,
	input  lsre_pkg::raw_item_t                raw_item,
	// expanded samples
	output logic                               smp_valid,
	input  logic                               smp_ready,
	output lsre_pkg::sample_item_t             smp_item
);
	import lsre_pkg::*;

	cfg_t       cfg_q;
	logic       push_valid;
	logic       push_ready;
	run_entry_t push_entry;
	logic       pop_valid;
	logic       pop_ready;
	run_entry_t pop_entry;

	// Configuration registers. The user must make writes land only while the block is idle;
	// the block does not enforce this and takes them straight away; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rlc_width         <= RST_RLC_WIDTH;
			cfg_q.sample_bits       <= RST_SAMPLE_BITS;
			cfg_q.trigger_raw_index <= RST_TRIGGER;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RLC_WIDTH:   cfg_q.rlc_width         <= cfg_wdata[RLC_W-1:0];
				CFG_SAMPLE_BITS: cfg_q.sample_bits       <= cfg_wdata[DW_W-1:0];
				CFG_TRIGGER_IDX: cfg_q.trigger_raw_index <= cfg_wdata[TRIG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: decode the raw word, track the word index against the trigger
	lsre_front #(
		.MAX_RLC_WIDTH  (MAX_RLC_WIDTH),
		.RAW_INDEX_WIDTH(RAW_INDEX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.raw_item  (raw_item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	// Queue: decouple word intake from run expansion
	lsre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	// Back: repeat each run's sample, mark run end and capture end
	lsre_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.smp_valid(smp_valid),
		.smp_ready(smp_ready),
		.smp_item (smp_item)
	);

endmodule

// ===== sv/lsre_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsre_checker
// Port-level checks of the expander's sample stream.
// ----------------------------------------------------------------------------
`include "logic_sample_runlength_expander_defines.svh"

module lsre_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   smp_valid,
	input logic                   smp_ready,
	input lsre_pkg::sample_item_t smp_item
);
	import lsre_pkg::*;

	// a stalled sample holds
	`LSRE_ASSERT_NEXT(a_stall_hold, smp_valid && !smp_ready, smp_valid && $stable(smp_item), "sample changed while stalled")

	// end of capture only on the end of a run
	`LSRE_ASSERT_NOW(a_cap_in_run, smp_valid && smp_item.capture_last, smp_item.run_last, "capture_last without run_last")

	// inside a run, the next copy follows at once with the same sample and tag
	`LSRE_ASSERT_NEXT(a_run_repeat, smp_valid && smp_ready && !smp_item.run_last, smp_valid && (smp_item.sample == $past(smp_item.sample)) && (smp_item.pre_trigger == $past(smp_item.pre_trigger)), "run copy broken")

endmodule

bind logic_sample_runlength_expander lsre_checker u_lsre_checker (.*);
